>>> rtl/lpcp_pkg.sv
// ----------------------------------------------------------------------------
// Lidar point camera projection package
// Shared constants, register indexes and status codes of the projection block.
// ----------------------------------------------------------------------------
package lpcp_pkg;

  localparam int COORD_WIDTH_DEF       = 20;
  localparam int PIXEL_INDEX_WIDTH_DEF = 12;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;

  typedef enum logic [2:0] {
    REG_EXT_ROW0   = 3'd0,
    REG_EXT_ROW1   = 3'd1,
    REG_EXT_ROW2   = 3'd2,
    REG_FOCAL      = 3'd3,
    REG_PRINCIPAL  = 3'd4,
    REG_IMG_WIDTH  = 3'd5,
    REG_IMG_HEIGHT = 3'd6,
    REG_MAX_DEPTH  = 3'd7
  } reg_idx_t;

  localparam logic [31:0] FOCAL_RESET     = 32'd951335099;
  localparam logic [31:0] PRINCIPAL_RESET = 32'd376973216;
  localparam logic [12:0] IMG_WIDTH_RESET  = 13'd1280;
  localparam logic [12:0] IMG_HEIGHT_RESET = 13'd720;
  localparam logic [18:0] MAX_DEPTH_RESET  = 19'd3072;

  localparam logic [1:0] ST_INSIDE  = 2'd0;
  localparam logic [1:0] ST_BEHIND  = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic [15:0] COLOR_SCALE_SQ = 16'd65025;

endpackage

>>> rtl/lpcp_point_if.sv
// ----------------------------------------------------------------------------
// Lidar point channel
// Carries one lidar point request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpcp_point_if #(
  parameter int COORD_WIDTH = lpcp_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

>>> rtl/lpcp_pixel_if.sv
// ----------------------------------------------------------------------------
// Projected pixel channel
// Carries one projection result request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpcp_pixel_if #(
  parameter int PIXEL_INDEX_WIDTH = lpcp_pkg::PIXEL_INDEX_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [PIXEL_INDEX_WIDTH-1:0] pixel_col;
  logic [PIXEL_INDEX_WIDTH-1:0] pixel_row;
  logic [7:0]                   blue_level;
  logic [7:0]                   red_level;

  modport source (output valid, output status, output pixel_col, output pixel_row,
                  output blue_level, output red_level, input ready);
  modport sink   (input valid, input status, input pixel_col, input pixel_row,
                  input blue_level, input red_level, output ready);
endinterface

>>> rtl/lidar_point_camera_projection.sv
// ----------------------------------------------------------------------------
// Lidar point camera projection
// Moves lidar points into the camera frame, projects them through a pinhole
// model and colors them by depth.
// ----------------------------------------------------------------------------
// The block accepts one point per clock while its skid buffer is empty and
// returns one result per point, in order. The pipeline holds five arithmetic
// stages, 28 square root stages, ten stages for the division by max_depth and
// the output register itself. The pipeline depth is set by
// the 28-step pipelined square root of the scaled squared depth and the 9-step
// pipelined division by max_depth; the pixel divisions run in parallel with the
// square root. A two-entry output buffer keeps the input open while one result
// waits to be taken. Configuration registers must only be written while no
// point is in flight.
module lidar_point_camera_projection #(
  parameter int COORD_WIDTH       = lpcp_pkg::COORD_WIDTH_DEF,
  parameter int PIXEL_INDEX_WIDTH = lpcp_pkg::PIXEL_INDEX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lpcp_point_if.sink                      in_pt,
  lpcp_pixel_if.source                    out_px,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [lpcp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [lpcp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [lpcp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int C      = COORD_WIDTH;
  localparam int P      = PIXEL_INDEX_WIDTH;
  localparam int PROD_W = C + 16;
  localparam int ACC_W  = C + 18;
  localparam int CAM_W  = ACC_W - 14;
  localparam int GATE_W = CAM_W + 1;
  localparam int MUL_W  = CAM_W + 17;
  localparam int NUM_W  = CAM_W + 18;
  localparam int DEN_W  = CAM_W + 4;
  localparam int CMP_W  = NUM_W + P;
  localparam int D2_W   = 40;
  localparam int T_W    = 56;
  localparam int S_W    = 28;
  localparam int SR_W   = 58;
  localparam int SQ_N   = S_W;
  localparam int MQ     = 9;
  localparam int MC_W   = S_W + 1;
  localparam int LIM_W  = (P + 1 > 13) ? P + 1 : 13;

  localparam logic signed [GATE_W-1:0] GATE_LIM = GATE_W'(524288);
  localparam logic [LIM_W-1:0]         PIX_LIM  = LIM_W'(1) << P;

  typedef struct packed {
    logic             behind;
    logic             gate;
    logic             tzero;
    logic [CMP_W-1:0] ur;
    logic [CMP_W-1:0] vr;
    logic [P-1:0]     uq;
    logic [P-1:0]     vq;
    logic             un;
    logic             vn;
    logic             us;
    logic             vs;
    logic [DEN_W-1:0] den;
    logic [SR_W-1:0]  sr;
    logic [S_W-1:0]   sq;
  } chain_t;

  typedef struct packed {
    logic            behind;
    logic            gate;
    logic            tzero;
    logic            outside;
    logic [P-1:0]    uq;
    logic [P-1:0]    vq;
    logic            exact;
    logic [MC_W-1:0] mr;
    logic [MQ-1:0]   mq;
    logic            msat;
  } mdiv_t;

  typedef struct packed {
    logic [1:0]   status;
    logic [P-1:0] col;
    logic [P-1:0] row;
    logic [7:0]   blue;
    logic [7:0]   red;
  } res_t;

  // Configuration registers.
  logic [63:0] ext_r [3];
  logic [31:0] focal_r;
  logic [31:0] pp_r;
  logic [12:0] iw_r;
  logic [12:0] ih_r;
  logic [18:0] depth_r;
  lpcp_pkg::reg_idx_t cfg_idx;
  logic               cfg_wr;

  assign cfg_idx    = lpcp_pkg::reg_idx_t'(cfg_paddr[5:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r[0] <= '0;
      ext_r[1] <= '0;
      ext_r[2] <= '0;
      focal_r  <= lpcp_pkg::FOCAL_RESET;
      pp_r     <= lpcp_pkg::PRINCIPAL_RESET;
      iw_r     <= lpcp_pkg::IMG_WIDTH_RESET;
      ih_r     <= lpcp_pkg::IMG_HEIGHT_RESET;
      depth_r  <= lpcp_pkg::MAX_DEPTH_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lpcp_pkg::REG_EXT_ROW0:   ext_r[0] <= cfg_pwdata;
        lpcp_pkg::REG_EXT_ROW1:   ext_r[1] <= cfg_pwdata;
        lpcp_pkg::REG_EXT_ROW2:   ext_r[2] <= cfg_pwdata;
        lpcp_pkg::REG_FOCAL:      focal_r  <= cfg_pwdata[31:0];
        lpcp_pkg::REG_PRINCIPAL:  pp_r     <= cfg_pwdata[31:0];
        lpcp_pkg::REG_IMG_WIDTH:  iw_r     <= cfg_pwdata[12:0];
        lpcp_pkg::REG_IMG_HEIGHT: ih_r     <= cfg_pwdata[12:0];
        lpcp_pkg::REG_MAX_DEPTH:  depth_r  <= cfg_pwdata[18:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lpcp_pkg::REG_EXT_ROW0:   cfg_prdata = ext_r[0];
      lpcp_pkg::REG_EXT_ROW1:   cfg_prdata = ext_r[1];
      lpcp_pkg::REG_EXT_ROW2:   cfg_prdata = ext_r[2];
      lpcp_pkg::REG_FOCAL:      cfg_prdata = {32'd0, focal_r};
      lpcp_pkg::REG_PRINCIPAL:  cfg_prdata = {32'd0, pp_r};
      lpcp_pkg::REG_IMG_WIDTH:  cfg_prdata = {51'd0, iw_r};
      lpcp_pkg::REG_IMG_HEIGHT: cfg_prdata = {51'd0, ih_r};
      lpcp_pkg::REG_MAX_DEPTH:  cfg_prdata = {45'd0, depth_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  logic [18:0]      mdepth;
  logic [LIM_W-1:0] wlim;
  logic [LIM_W-1:0] hlim;

  assign mdepth = (depth_r == '0) ? 19'd1 : depth_r;
  assign wlim   = (LIM_W'(iw_r) > PIX_LIM) ? PIX_LIM : LIM_W'(iw_r);
  assign hlim   = (LIM_W'(ih_r) > PIX_LIM) ? PIX_LIM : LIM_W'(ih_r);

  // Pipeline control.
  logic en;
  logic skid_full_r;
  assign en          = !skid_full_r;
  assign in_pt.ready = en;

  // Stage 1: rotation products.
  logic                     v1_r;
  logic signed [PROD_W-1:0] prod_r [3][3];
  logic signed [15:0]       trans_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_pt.valid;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[r][0] <= $signed(ext_r[r][15:0])  * in_pt.point_x;
        prod_r[r][1] <= $signed(ext_r[r][31:16]) * in_pt.point_y;
        prod_r[r][2] <= $signed(ext_r[r][47:32]) * in_pt.point_z;
        trans_r[r]   <= $signed(ext_r[r][63:48]);
      end
    end
  end

  // Stage 2: camera coordinates, rounded toward minus infinity.
  logic                    v2_r;
  logic signed [CAM_W-1:0] cam_r [3];
  logic signed [ACC_W-1:0] acc_nxt [3];

  for (genvar r = 0; r < 3; r++) begin : g_acc
    always_comb begin
      acc_nxt[r] = ACC_W'(prod_r[r][0]) + ACC_W'(prod_r[r][1]) + ACC_W'(prod_r[r][2])
                 + {{(ACC_W - 30){trans_r[r][15]}}, trans_r[r], 14'd0};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cam_r[r] <= acc_nxt[r][ACC_W-1:14];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  // Stage 3: projection products and squares.
  logic                    v3_r;
  logic                    behind3_r;
  logic                    gate3_r;
  logic signed [MUL_W-1:0] fxc0_r, cxc2_r, fyc1_r, cyc2_r;
  logic signed [39:0]      sqr_r [3];
  logic [DEN_W-1:0]        den3_r;
  logic [2:0]              gate_nxt;

  for (genvar r = 0; r < 3; r++) begin : g_sq
    assign gate_nxt[r] = (GATE_W'(cam_r[r]) < GATE_LIM) && (GATE_W'(cam_r[r]) > -GATE_LIM);
    always_ff @(posedge clk) begin
      if (en) begin
        sqr_r[r] <= $signed(cam_r[r][19:0]) * $signed(cam_r[r][19:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      behind3_r <= cam_r[2][CAM_W-1] || (cam_r[2] == '0);
      gate3_r   <= &gate_nxt;
      fxc0_r    <= $signed({1'b0, focal_r[15:0]})  * cam_r[0];
      fyc1_r    <= $signed({1'b0, focal_r[31:16]}) * cam_r[1];
      cxc2_r    <= $signed({1'b0, pp_r[15:0]})     * cam_r[2];
      cyc2_r    <= $signed({1'b0, pp_r[31:16]})    * cam_r[2];
      den3_r    <= {cam_r[2], 4'd0};
    end
  end

  // Stage 4: numerators and squared depth.
  logic                    v4_r;
  logic                    behind4_r;
  logic                    gate4_r;
  logic signed [NUM_W-1:0] numu_r, numv_r;
  logic [DEN_W-1:0]        den4_r;
  logic [D2_W-1:0]         d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      behind4_r <= behind3_r;
      gate4_r   <= gate3_r;
      numu_r    <= NUM_W'(fxc0_r) + NUM_W'(cxc2_r);
      numv_r    <= NUM_W'(fyc1_r) + NUM_W'(cyc2_r);
      den4_r    <= den3_r;
      d2_r      <= D2_W'(unsigned'(sqr_r[0])) + D2_W'(unsigned'(sqr_r[1]))
                 + D2_W'(unsigned'(sqr_r[2]));
    end
  end

  // Stage 5: magnitudes, range checks and the scaled squared depth.
  chain_t           ch_r [SQ_N + 1];
  logic [SQ_N:0]    chv_r;
  chain_t           ch0_nxt;
  logic [NUM_W-1:0] absu, absv;
  logic [T_W-1:0]   tval;

  always_comb begin
    absu    = numu_r[NUM_W-1] ? unsigned'(-numu_r) : unsigned'(numu_r);
    absv    = numv_r[NUM_W-1] ? unsigned'(-numv_r) : unsigned'(numv_r);
    tval    = (gate4_r ? d2_r : '0) * lpcp_pkg::COLOR_SCALE_SQ;
    ch0_nxt = '0;
    ch0_nxt.behind = behind4_r;
    ch0_nxt.gate   = gate4_r;
    ch0_nxt.tzero  = (d2_r == '0) || !gate4_r;
    ch0_nxt.ur     = CMP_W'(absu);
    ch0_nxt.vr     = CMP_W'(absv);
    ch0_nxt.un     = numu_r[NUM_W-1];
    ch0_nxt.vn     = numv_r[NUM_W-1];
    ch0_nxt.us     = CMP_W'(absu) >= (CMP_W'(den4_r) << P);
    ch0_nxt.vs     = CMP_W'(absv) >= (CMP_W'(den4_r) << P);
    ch0_nxt.den    = den4_r;
    ch0_nxt.sr     = SR_W'(tval);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch_r[0] <= ch0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chv_r <= '0;
    end else if (en) begin
      chv_r <= {chv_r[SQ_N-1:0], v4_r};
    end
  end

  // Square root stages, one result bit each; the pixel divisions share the first P of them.
  for (genvar j = 0; j < SQ_N; j++) begin : g_chain
    localparam int B = S_W - 1 - j;
    chain_t          nxt;
    logic [SR_W-1:0] trial;

    if (j < P) begin : g_div
      localparam int BU = P - 1 - j;
      logic [CMP_W-1:0] dsh;
      always_comb begin
        dsh   = CMP_W'(ch_r[j].den) << BU;
        trial = (SR_W'(ch_r[j].sq) << (B + 1)) + (SR_W'(1) << (2 * B));
        nxt   = ch_r[j];
        if (ch_r[j].sr >= trial) begin
          nxt.sr    = ch_r[j].sr - trial;
          nxt.sq[B] = 1'b1;
        end
        if (ch_r[j].ur >= dsh) begin
          nxt.ur     = ch_r[j].ur - dsh;
          nxt.uq[BU] = 1'b1;
        end
        if (ch_r[j].vr >= dsh) begin
          nxt.vr     = ch_r[j].vr - dsh;
          nxt.vq[BU] = 1'b1;
        end
      end
    end else begin : g_nodiv
      always_comb begin
        trial = (SR_W'(ch_r[j].sq) << (B + 1)) + (SR_W'(1) << (2 * B));
        nxt   = ch_r[j];
        if (ch_r[j].sr >= trial) begin
          nxt.sr    = ch_r[j].sr - trial;
          nxt.sq[B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ch_r[j + 1] <= nxt;
      end
    end
  end

  // Division of the root by max_depth, one quotient bit per stage.
  mdiv_t         md_r [MQ + 1];
  logic [MQ:0]   mdv_r;
  mdiv_t         md0_nxt;
  chain_t        chl;

  assign chl = ch_r[SQ_N];

  always_comb begin
    md0_nxt         = '0;
    md0_nxt.behind  = chl.behind;
    md0_nxt.gate    = chl.gate;
    md0_nxt.tzero   = chl.tzero;
    md0_nxt.outside = chl.us || chl.vs || (chl.un && (chl.uq != '0))
                   || (chl.vn && (chl.vq != '0))
                   || (LIM_W'(chl.uq) >= wlim) || (LIM_W'(chl.vq) >= hlim);
    md0_nxt.uq      = chl.uq;
    md0_nxt.vq      = chl.vq;
    md0_nxt.exact   = (chl.sr == '0);
    md0_nxt.mr      = MC_W'(chl.sq);
    md0_nxt.msat    = MC_W'(chl.sq) >= (MC_W'(mdepth) << MQ);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_r[0] <= md0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mdv_r <= '0;
    end else if (en) begin
      mdv_r <= {mdv_r[MQ-1:0], chv_r[SQ_N]};
    end
  end

  for (genvar k = 0; k < MQ; k++) begin : g_mdiv
    localparam int BM = MQ - 1 - k;
    mdiv_t           nxt;
    logic [MC_W-1:0] msh;
    always_comb begin
      msh = MC_W'(mdepth) << BM;
      nxt = md_r[k];
      if (md_r[k].mr >= msh) begin
        nxt.mr     = md_r[k].mr - msh;
        nxt.mq[BM] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        md_r[k + 1] <= nxt;
      end
    end
  end

  // Result formatting.
  mdiv_t      mdl;
  res_t       res_nxt;
  logic [9:0] gval;
  logic       gdec;
  logic [7:0] red_v, blue_v;

  assign mdl = md_r[MQ];

  always_comb begin
    gdec = mdl.exact && (mdl.mr == '0) && !mdl.tzero;
    gval = {1'b0, mdl.mq} - {9'd0, gdec};
    if (!mdl.gate) begin
      red_v  = 8'd255;
      blue_v = 8'd0;
    end else begin
      red_v  = (mdl.msat || (mdl.mq >= 9'd255)) ? 8'd255 : mdl.mq[7:0];
      if (mdl.tzero) begin
        blue_v = 8'd255;
      end else if (mdl.msat || (gval >= 10'd255)) begin
        blue_v = 8'd0;
      end else begin
        blue_v = 8'(10'd254 - gval);
      end
    end
    res_nxt = '0;
    if (mdl.behind) begin
      res_nxt.status = lpcp_pkg::ST_BEHIND;
    end else if (mdl.outside) begin
      res_nxt.status = lpcp_pkg::ST_OUTSIDE;
    end else begin
      res_nxt.status = lpcp_pkg::ST_INSIDE;
      res_nxt.col    = mdl.uq;
      res_nxt.row    = mdl.vq;
      res_nxt.blue   = blue_v;
      res_nxt.red    = red_v;
    end
  end

  // Output register and skid buffer.
  logic out_valid_r;
  res_t out_r;
  res_t skid_r;
  logic push;
  logic take;

  assign push = en && mdv_r[MQ];
  assign take = out_valid_r && out_px.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (take) begin
        skid_full_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_full_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_r <= res_nxt;
      end else begin
        skid_r <= res_nxt;
      end
    end
  end

  assign out_px.valid      = out_valid_r;
  assign out_px.status     = out_r.status;
  assign out_px.pixel_col  = out_r.col;
  assign out_px.pixel_row  = out_r.row;
  assign out_px.blue_level = out_r.blue;
  assign out_px.red_level  = out_r.red;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid buffer holds a result while the output register is empty");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != lpcp_pkg::ST_INSIDE)) |->
      (out_r.col == '0 && out_r.row == '0 && out_r.blue == '0 && out_r.red == '0))
    else $error("rejected point carries nonzero fields");

  a_inside_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == lpcp_pkg::ST_INSIDE)) |->
      ((LIM_W'(out_r.col) < wlim) && (LIM_W'(out_r.row) < hlim)))
    else $error("projected pixel lies outside the image");

  a_color_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == lpcp_pkg::ST_INSIDE)) |->
      ((9'(out_r.red) + 9'(out_r.blue)) <= 9'd255))
    else $error("depth colors exceed full scale together");

endmodule
